FILE: rtl/irpsd_pkg.sv
// Shared types, constants and window-match helpers for the IR pulse/space decoder.
// Depends on nothing; used by ir_pulse_space_decoder_core.
`timescale 1ns / 1ps
`default_nettype none

package irpsd_pkg;

  // Field and storage widths
  localparam int unsigned DURATION_BITS = 16;
  localparam int unsigned WORD_BITS     = 32;
  localparam int unsigned DATA_BITS     = 32;
  localparam int unsigned COUNT_BITS    = 6;
  localparam int unsigned STATE_BITS    = 3;
  localparam int unsigned ADDR_BITS     = 5;
  localparam int unsigned APB_DATA_BITS = 32;

  localparam logic [COUNT_BITS-1:0] FRAME_BITS_RESET = COUNT_BITS'(32);

  // Request opcodes
  localparam logic OP_EDGE    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  // Register indexes (word address)
  localparam logic [2:0] REG_HDR_FIRST  = 3'd0;
  localparam logic [2:0] REG_HDR_SECOND = 3'd1;
  localparam logic [2:0] REG_ONE_PULSE  = 3'd2;
  localparam logic [2:0] REG_ONE_SPACE  = 3'd3;
  localparam logic [2:0] REG_ZERO_PULSE = 3'd4;
  localparam logic [2:0] REG_ZERO_SPACE = 3'd5;
  localparam logic [2:0] REG_FRAME_BITS = 3'd6;

  // Reported receiver state codes
  localparam logic [STATE_BITS-1:0] RX_IDLE        = 3'd0;
  localparam logic [STATE_BITS-1:0] RX_HDR_FIRST   = 3'd1;
  localparam logic [STATE_BITS-1:0] RX_HDR_SECOND  = 3'd2;
  localparam logic [STATE_BITS-1:0] RX_FIRST_EDGE  = 3'd3;
  localparam logic [STATE_BITS-1:0] RX_SECOND_EDGE = 3'd4;
  localparam logic [STATE_BITS-1:0] RX_DONE        = 3'd5;
  localparam logic [STATE_BITS-1:0] RX_REJECTED    = 3'd6;

  // Receiver state, one-hot
  typedef enum logic [6:0] {
    ST_IDLE        = 7'b0000001,
    ST_HDR_FIRST   = 7'b0000010,
    ST_HDR_SECOND  = 7'b0000100,
    ST_FIRST_EDGE  = 7'b0001000,
    ST_SECOND_EDGE = 7'b0010000,
    ST_DONE        = 7'b0100000,
    ST_REJECTED    = 7'b1000000
  } rx_state_e;

  typedef struct packed {
    logic                     op;
    logic [DURATION_BITS-1:0] duration;
  } edge_req_t;

  typedef struct packed {
    logic [STATE_BITS-1:0] rx_state;
    logic [DATA_BITS-1:0]  data_word;
    logic [COUNT_BITS-1:0] bits_received;
    logic                  frame_done;
    logic                  frame_rejected;
  } frame_res_t;

  // Header check: nominal strictly within +/- nominal/8 of the measurement
  function automatic logic hdr_match(input logic [DURATION_BITS-1:0] nominal,
                                     input logic [DURATION_BITS-1:0] meas);
    logic [DURATION_BITS:0] n;
    logic [DURATION_BITS:0] m;
    logic [DURATION_BITS:0] t;
    n = {1'b0, nominal};
    m = {1'b0, meas};
    t = {4'b0, nominal[DURATION_BITS-1:3]};
    return (n < m + t) && (n + t > m);
  endfunction

  // Bit check: nominal strictly within +/- meas/4 of the measurement
  function automatic logic bit_match(input logic [DURATION_BITS-1:0] nominal,
                                     input logic [DURATION_BITS-1:0] meas);
    logic [DURATION_BITS:0] n;
    logic [DURATION_BITS:0] m;
    logic [DURATION_BITS:0] t;
    n = {1'b0, nominal};
    m = {1'b0, meas};
    t = {3'b0, meas[DURATION_BITS-1:2]};
    return (n < m + t) && (n + t > m);
  endfunction

  // Map the one-hot state to its reported code
  function automatic logic [STATE_BITS-1:0] state_code(input rx_state_e st);
    logic [STATE_BITS-1:0] code;
    unique case (st)
      ST_IDLE:        code = RX_IDLE;
      ST_HDR_FIRST:   code = RX_HDR_FIRST;
      ST_HDR_SECOND:  code = RX_HDR_SECOND;
      ST_FIRST_EDGE:  code = RX_FIRST_EDGE;
      ST_SECOND_EDGE: code = RX_SECOND_EDGE;
      ST_DONE:        code = RX_DONE;
      ST_REJECTED:    code = RX_REJECTED;
      default:        code = RX_IDLE;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/ir_pulse_space_decoder_core.sv
// Pipeline: a request accepted into the input register is decoded from there into the
// state and result register, and its result then stays on the port until it is taken;
// with no stall on the result side one request is taken every cycle, set by the single
// decode pass between the two registers.
// Reset (rst_ni low, asynchronous) empties both stages, returns the receiver to idle
// with a cleared word and count, and loads the registers with their reset values.
// Top level of the IR pulse/space decoder: APB registers, input stage, decode, result.
// Depends on irpsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ir_pulse_space_decoder_core
  import irpsd_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  // edge request channel
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire edge_req_t                in_req_i,
  // frame result channel
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output frame_res_t                    out_res_o,
  // register port
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [ADDR_BITS-1:0]     paddr,
  input  wire logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0]      prdata,
  output logic                          pready
);

  // Register file
  logic [DURATION_BITS-1:0] hdr_first_q, hdr_second_q;
  logic [DURATION_BITS-1:0] one_pulse_q, one_space_q;
  logic [DURATION_BITS-1:0] zero_pulse_q, zero_space_q;
  logic [COUNT_BITS-1:0]    frame_bits_q;
  logic                     cfg_wr;
  logic [2:0]               reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  // Write the addressed register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_first_q  <= '0;
      hdr_second_q <= '0;
      one_pulse_q  <= '0;
      one_space_q  <= '0;
      zero_pulse_q <= '0;
      zero_space_q <= '0;
      frame_bits_q <= FRAME_BITS_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_HDR_FIRST:  hdr_first_q  <= pwdata[DURATION_BITS-1:0];
        REG_HDR_SECOND: hdr_second_q <= pwdata[DURATION_BITS-1:0];
        REG_ONE_PULSE:  one_pulse_q  <= pwdata[DURATION_BITS-1:0];
        REG_ONE_SPACE:  one_space_q  <= pwdata[DURATION_BITS-1:0];
        REG_ZERO_PULSE: zero_pulse_q <= pwdata[DURATION_BITS-1:0];
        REG_ZERO_SPACE: zero_space_q <= pwdata[DURATION_BITS-1:0];
        REG_FRAME_BITS: frame_bits_q <= pwdata[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_HDR_FIRST:  prdata = APB_DATA_BITS'(hdr_first_q);
      REG_HDR_SECOND: prdata = APB_DATA_BITS'(hdr_second_q);
      REG_ONE_PULSE:  prdata = APB_DATA_BITS'(one_pulse_q);
      REG_ONE_SPACE:  prdata = APB_DATA_BITS'(one_space_q);
      REG_ZERO_PULSE: prdata = APB_DATA_BITS'(zero_pulse_q);
      REG_ZERO_SPACE: prdata = APB_DATA_BITS'(zero_space_q);
      REG_FRAME_BITS: prdata = APB_DATA_BITS'(frame_bits_q);
      default:        prdata = '0;
    endcase
  end

  // Input stage and handshake
  logic      in_valid_q;
  edge_req_t in_q;
  logic      out_valid_q;
  frame_res_t res_q, res_d;
  logic      advance;
  logic      step;

  assign advance    = !out_valid_q || out_ready_i;
  assign step       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // Hold the request payload
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_req_i;
    end
  end

  // Receiver state
  rx_state_e                state_q, state_d;
  logic [DURATION_BITS-1:0] held_q, held_d;
  logic [COUNT_BITS-1:0]    bit_idx_q, bit_idx_d;
  logic [WORD_BITS-1:0]     word_q, word_d;
  logic                     one_ok, zero_ok;

  assign one_ok  = bit_match(one_pulse_q, held_q) && bit_match(one_space_q, in_q.duration);
  assign zero_ok = bit_match(zero_pulse_q, held_q) && bit_match(zero_space_q, in_q.duration);

  // Decode one edge
  always_comb begin
    state_d   = state_q;
    held_d    = held_q;
    bit_idx_d = bit_idx_q;
    word_d    = word_q;
    if (step) begin
      if (in_q.op == OP_RESTART) begin
        state_d   = ST_IDLE;
        held_d    = '0;
        bit_idx_d = '0;
        word_d    = '0;
      end else begin
        unique case (state_q)
          ST_IDLE:       state_d = ST_HDR_FIRST;
          ST_HDR_FIRST:  state_d = hdr_match(hdr_first_q, in_q.duration) ?
                                   ST_HDR_SECOND : ST_REJECTED;
          ST_HDR_SECOND: state_d = hdr_match(hdr_second_q, in_q.duration) ?
                                   ST_FIRST_EDGE : ST_REJECTED;
          ST_FIRST_EDGE: begin
            held_d  = in_q.duration;
            state_d = ST_SECOND_EDGE;
          end
          ST_SECOND_EDGE: begin
            if (bit_idx_q < frame_bits_q) begin
              if (one_ok || zero_ok) begin
                word_d    = {word_q[WORD_BITS-2:0], (held_q > in_q.duration)};
                bit_idx_d = bit_idx_q + COUNT_BITS'(1);
                state_d   = ST_FIRST_EDGE;
              end else begin
                state_d = ST_REJECTED;
              end
            end else begin
              state_d = ST_DONE;
            end
          end
          ST_DONE, ST_REJECTED: ;
          default: state_d = ST_IDLE;
        endcase
      end
    end
  end

  // Build the result from the state after the step
  always_comb begin
    res_d.rx_state       = state_code(state_d);
    res_d.data_word      = word_d[DATA_BITS-1:0];
    res_d.bits_received  = bit_idx_d;
    res_d.frame_done     = (state_d == ST_DONE);
    res_d.frame_rejected = (state_d == ST_REJECTED);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      held_q      <= '0;
      bit_idx_q   <= '0;
      word_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      held_q    <= held_d;
      bit_idx_q <= bit_idx_d;
      word_q    <= word_d;
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  // Load the result register
  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

`ifndef ASSERT_OFF
  // A finished frame stays done until a restart is decoded
  a_done_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && !(step && in_q.op == OP_RESTART)) |=> state_q == ST_DONE)
    else $error("done state left without restart");

  // The bit count only advances by one or clears
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bit_idx_q != $past(bit_idx_q)) |->
      (bit_idx_q == $past(bit_idx_q) + COUNT_BITS'(1) || bit_idx_q == '0))
    else $error("bit count jumped");

  // State changes only when a request is decoded
  a_state_on_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step |=> $stable(state_q))
    else $error("state changed without a request");

  // Done and rejected are never reported together
  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_res_o.frame_done && out_res_o.frame_rejected))
    else $error("done and rejected both set");
`endif

endmodule

`default_nettype wire

FILE: tb/tb_ir_pulse_space_decoder_core.sv
// Self-checking bench for ir_pulse_space_decoder_core: drives edge-duration requests
// and APB register writes, predicts every frame result and compares it field by field.
// Depends on irpsd_pkg and ir_pulse_space_decoder_core.
`timescale 1ns / 1ps

module tb_ir_pulse_space_decoder_core;
  import irpsd_pkg::*;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  edge_req_t                in_req_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  frame_res_t               out_res_o;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [ADDR_BITS-1:0]     paddr = '0;
  logic [APB_DATA_BITS-1:0] pwdata = '0;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;

  // Shadow registers, as last written over APB
  logic [DURATION_BITS-1:0] cfg_time [0:5] = '{default: '0};
  logic [COUNT_BITS-1:0]    cfg_frame_bits = FRAME_BITS_RESET;

  // Predicted receiver state
  logic [STATE_BITS-1:0]    rx_st = RX_IDLE;
  logic [DURATION_BITS-1:0] held_pulse = '0;
  logic [COUNT_BITS-1:0]    bit_cnt = '0;
  logic [WORD_BITS-1:0]     shift_q = '0;

  frame_res_t  decoded_q [$];
  int unsigned miss_count = 0;
  int unsigned sent_count = 0;
  int unsigned hold_off_len = 0;
  bit          idle_on = 1'b1;

  ir_pulse_space_decoder_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_res_o  (out_res_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Strict window: nominal inside (center - tol, center + tol), signed
  function automatic bit in_tolerance(int nominal, int center, int tol);
    return (nominal < center + tol) && (nominal > center - tol);
  endfunction

  function automatic bit pair_matches(logic [DURATION_BITS-1:0] p,
                                      logic [DURATION_BITS-1:0] s);
    int tp;
    int ts;
    bit one;
    bit zero;
    tp = p >> 2;
    ts = s >> 2;
    one  = in_tolerance(cfg_time[REG_ONE_PULSE], p, tp) &&
           in_tolerance(cfg_time[REG_ONE_SPACE], s, ts);
    zero = in_tolerance(cfg_time[REG_ZERO_PULSE], p, tp) &&
           in_tolerance(cfg_time[REG_ZERO_SPACE], s, ts);
    return one || zero;
  endfunction

  // Advance the predicted receiver by one request and return the frame status
  function automatic frame_res_t decode_request(edge_req_t req);
    frame_res_t res;
    if (req.op == OP_RESTART) begin
      rx_st      = RX_IDLE;
      held_pulse = '0;
      bit_cnt    = '0;
      shift_q    = '0;
    end else begin
      case (rx_st)
        RX_IDLE: begin
          rx_st = RX_HDR_FIRST;
        end
        RX_HDR_FIRST: begin
          rx_st = in_tolerance(cfg_time[REG_HDR_FIRST], req.duration,
                               cfg_time[REG_HDR_FIRST] >> 3) ? RX_HDR_SECOND : RX_REJECTED;
        end
        RX_HDR_SECOND: begin
          rx_st = in_tolerance(cfg_time[REG_HDR_SECOND], req.duration,
                               cfg_time[REG_HDR_SECOND] >> 3) ? RX_FIRST_EDGE : RX_REJECTED;
        end
        RX_FIRST_EDGE: begin
          held_pulse = req.duration;
          rx_st      = RX_SECOND_EDGE;
        end
        RX_SECOND_EDGE: begin
          if (bit_cnt < cfg_frame_bits) begin
            if (!pair_matches(held_pulse, req.duration)) begin
              rx_st = RX_REJECTED;
            end else begin
              shift_q = {shift_q[WORD_BITS-2:0], held_pulse > req.duration};
              bit_cnt = bit_cnt + 1'b1;
              rx_st   = RX_FIRST_EDGE;
            end
          end else begin
            // frame complete: the trailing space is not checked
            rx_st = RX_DONE;
          end
        end
        default: begin
        end
      endcase
    end
    res.rx_state       = rx_st;
    res.data_word      = shift_q[DATA_BITS-1:0];
    res.bits_received  = bit_cnt;
    res.frame_done     = (rx_st == RX_DONE);
    res.frame_rejected = (rx_st == RX_REJECTED);
    return res;
  endfunction

  // Predict on every accepted request
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      decoded_q.push_back(decode_request(in_req_i));
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      miss_count++;
      if (miss_count < 40) begin
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      end
    end
  endtask

  // Compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin : result_check
    frame_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (decoded_q.size() == 0) begin
        miss_count++;
        if (miss_count < 40) begin
          $display("%0t: result with no request pending, expected none actual %0h",
                   $time, out_res_o);
        end
      end else begin
        want = decoded_q.pop_front();
        check_field("rx_state", want.rx_state, out_res_o.rx_state);
        check_field("data_word", want.data_word, out_res_o.data_word);
        check_field("bits_received", want.bits_received, out_res_o.bits_received);
        check_field("frame_done", want.frame_done, out_res_o.frame_done);
        check_field("frame_rejected", want.frame_rejected, out_res_o.frame_rejected);
      end
    end
  end

  // Mostly short gaps, a few long ones; none while idling is off
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Drive result-side ready; a requested hold-off is counted here
  initial begin : result_ready_driver
    int unsigned n;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_off_len != 0) begin
        n = hold_off_len;
        hold_off_len = 0;
        out_ready_i <= 1'b0;
      end else begin
        n = pick_gap();
        if (n != 0) begin
          out_ready_i <= 1'b0;
        end else begin
          out_ready_i <= 1'b1;
          n = $urandom_range(1, 4);
        end
      end
      repeat (n) @(posedge clk_i);
    end
  end

  // Offer one request and hold it until accepted
  task automatic send_request(logic op, logic [DURATION_BITS-1:0] dur);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= '{op: op, duration: dur};
    do @(posedge clk_i); while (!in_ready_o);
    sent_count++;
  endtask

  // Drop valid and wait for every predicted result, then let the pipe settle
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [APB_DATA_BITS-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (idx == REG_FRAME_BITS) cfg_frame_bits = value[COUNT_BITS-1:0];
    else cfg_time[idx] = value[DURATION_BITS-1:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Program all registers, with junk above each field width
  task automatic set_timing(logic [15:0] h1, logic [15:0] h2, logic [15:0] op_t,
                            logic [15:0] os_t, logic [15:0] zp_t, logic [15:0] zs_t,
                            logic [5:0] nbits);
    cfg_write(REG_HDR_FIRST, {16'($urandom()), h1});
    cfg_write(REG_HDR_SECOND, {16'($urandom()), h2});
    cfg_write(REG_ONE_PULSE, {16'($urandom()), op_t});
    cfg_write(REG_ONE_SPACE, {16'($urandom()), os_t});
    cfg_write(REG_ZERO_PULSE, {16'($urandom()), zp_t});
    cfg_write(REG_ZERO_SPACE, {16'($urandom()), zs_t});
    cfg_write(REG_FRAME_BITS, {26'($urandom()), nbits});
  endtask

  // Duration inside the header window of a nominal time
  function automatic logic [15:0] near_header(logic [15:0] nominal);
    int t;
    int d;
    t = nominal >> 3;
    d = nominal;
    if (t > 1) d = d + int'($urandom_range(0, 2 * (t - 1))) - (t - 1);
    if (d > 65535) d = 65535;
    return d[15:0];
  endfunction

  // Duration within +/- nominal/8 of a nominal bit time, aimed at the bit window
  function automatic logic [15:0] near_bit(logic [15:0] nominal);
    int t;
    int d;
    t = nominal >> 3;
    d = nominal;
    if (t > 0) d = d + int'($urandom_range(0, 2 * t)) - t;
    if (d > 65535) d = 65535;
    return d[15:0];
  endfunction

  // Restart, then leader, header pair, bit pairs and trailing edges
  task automatic send_frame(int unsigned nbits, bit broken);
    logic [15:0] marks [$];
    bit          one;
    marks.push_back(16'($urandom()));
    marks.push_back(near_header(cfg_time[REG_HDR_FIRST]));
    marks.push_back(near_header(cfg_time[REG_HDR_SECOND]));
    for (int unsigned i = 0; i < nbits; i++) begin
      one = 1'($urandom_range(0, 1));
      marks.push_back(near_bit(one ? cfg_time[REG_ONE_PULSE] : cfg_time[REG_ZERO_PULSE]));
      marks.push_back(near_bit(one ? cfg_time[REG_ONE_SPACE] : cfg_time[REG_ZERO_SPACE]));
    end
    repeat (2 + $urandom_range(0, 2)) marks.push_back(16'($urandom()));
    if (broken) marks[$urandom_range(0, marks.size() - 1)] = 16'($urandom());
    send_request(OP_RESTART, 16'($urandom()));
    foreach (marks[i]) send_request(OP_EDGE, marks[i]);
  endtask

  task automatic send_noise(int unsigned n);
    repeat (n) begin
      send_request(($urandom_range(0, 6) == 0) ? OP_RESTART : OP_EDGE,
                   ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 64))
                                               : 16'($urandom()));
    end
  endtask

  task automatic run_chunk();
    int unsigned nbits;
    if ($urandom_range(0, 99) < 75) begin
      nbits = ($urandom_range(0, 99) < 85) ? 32'(cfg_frame_bits)
                                           : $urandom_range(0, cfg_frame_bits);
      send_frame(nbits, $urandom_range(0, 99) < 20);
    end else begin
      send_noise($urandom_range(1, 8));
    end
  endtask

  // Reset registers: zero header time never matches; sticky reject; restart
  task automatic test_header_window();
    send_request(OP_EDGE, 16'h0000);
    send_request(OP_EDGE, 16'h0000);
    send_request(OP_EDGE, 16'hFFFF);
    send_request(OP_RESTART, 16'hFFFF);
    drain();
    set_timing(16'hFFFF, 16'd16, 16'd600, 16'd1700, 16'd600, 16'd600, 6'd2);
    // widest header, then a measurement so short that the low bound goes negative
    send_request(OP_EDGE, 16'hFFFF);
    send_request(OP_EDGE, 16'hFFFF);
    send_request(OP_EDGE, 16'd0);
    send_request(OP_RESTART, 16'd0);
    send_request(OP_EDGE, 16'd0);
    send_request(OP_EDGE, 16'd57345);
    send_request(OP_EDGE, 16'd17);
    drain();
  endtask

  // Frame length zero: the first space after the header completes the frame
  task automatic test_empty_frame();
    cfg_write(REG_FRAME_BITS, 32'd0);
    send_request(OP_EDGE, 16'd600);
    send_request(OP_EDGE, 16'd1700);
    send_request(OP_EDGE, 16'd1700);
    drain();
  endtask

  // Two bits, then an unchecked trailing space that completes the frame
  task automatic test_short_frame();
    cfg_write(REG_FRAME_BITS, 32'd2);
    send_request(OP_RESTART, 16'd0);
    send_request(OP_EDGE, 16'd0);
    send_request(OP_EDGE, 16'hFFFF);
    send_request(OP_EDGE, 16'd16);
    send_request(OP_EDGE, 16'd600);
    send_request(OP_EDGE, 16'd1690);
    send_request(OP_EDGE, 16'd610);
    send_request(OP_EDGE, 16'd590);
    send_request(OP_EDGE, 16'd0);
    send_request(OP_EDGE, 16'd0);
    send_request(OP_RESTART, 16'd0);
    drain();
  endtask

  // Hold off results while requests keep coming, so the input stalls
  task automatic test_backpressure();
    set_timing(16'd9000, 16'd4500, 16'd560, 16'd1690, 16'd560, 16'd560, 6'd12);
    idle_on = 1'b0;
    hold_off_len = 300;
    send_frame(12, 1'b0);
    send_noise(10);
    drain();
    idle_on = 1'b1;
  endtask

  // Random frames over several register settings, extremes among them
  task automatic test_random_frames(int unsigned per_phase);
    int unsigned start;
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: set_timing(16'($urandom_range(16, 65535)), 16'($urandom_range(16, 65535)),
                      16'($urandom_range(4, 40000)), 16'($urandom_range(4, 40000)),
                      16'($urandom_range(4, 40000)), 16'($urandom_range(4, 40000)),
                      6'd32);
        1: set_timing(16'($urandom_range(16, 65535)), 16'($urandom_range(16, 65535)),
                      16'($urandom_range(4, 4000)), 16'($urandom_range(4, 4000)),
                      16'($urandom_range(4, 4000)), 16'($urandom_range(4, 4000)),
                      6'd0);
        // one-pattern unreachable (zero space), longest frame
        2: set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000,
                      16'($urandom_range(4, 65535)), 16'($urandom_range(4, 65535)),
                      6'd63);
        3: set_timing(16'd8, 16'd15, 16'd4, 16'd5, 16'd6, 16'd4, 6'd1);
        4: set_timing(16'($urandom_range(16, 65535)), 16'($urandom_range(16, 65535)),
                      16'($urandom_range(4, 40000)), 16'($urandom_range(4, 40000)),
                      16'($urandom_range(4, 40000)), 16'($urandom_range(4, 40000)),
                      6'd33);
        default: set_timing(16'($urandom_range(16, 65535)),
                            16'($urandom_range(16, 65535)),
                            16'($urandom_range(4, 40000)), 16'($urandom_range(4, 40000)),
                            16'($urandom_range(4, 40000)), 16'($urandom_range(4, 40000)),
                            6'($urandom_range(2, 24)));
      endcase
      idle_on = (p % 3) != 1;
      start = sent_count;
      while (sent_count - start < per_phase) begin
        run_chunk();
        // pause now and then until every result is back
        if ($urandom_range(0, 30) == 0) drain();
      end
      drain();
    end
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_header_window();
    test_empty_frame();
    test_short_frame();
    test_backpressure();
    test_random_frames(220);
    drain();
    repeat (10) @(posedge clk_i);
    if (miss_count == 0) begin
      $display("ir_pulse_space_decoder_core: match");
    end else begin
      $display("ir_pulse_space_decoder_core: mismatch");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run
  initial begin
    #8000000;
    $display("ir_pulse_space_decoder_core: mismatch");
    $finish;
  end

endmodule
